FILE: design/lasm_pkg.sv
package lasm_pkg;

  localparam int unsigned SymbolW  = 8;
  localparam int unsigned RowW     = 12;
  localparam int unsigned ColW     = 6;
  localparam int unsigned ScoreW   = 15;
  localparam int unsigned IndexW   = 18;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam int unsigned QueryLenDefault = 32;
  localparam int unsigned DbLenDefault    = 4096;

  localparam logic [ScoreW-1:0] ScoreMax = 15'h7FFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegMatch,
    RegMismatch,
    RegGapNorth,
    RegGapWest
  } cfg_reg_e;

  typedef enum logic {
    ActQuery,
    ActDatabase
  } action_e;

  typedef enum logic {
    KindCell,
    KindBest
  } kind_e;

  typedef enum logic [1:0] {
    DirRestart,
    DirDiag,
    DirNorth,
    DirWest
  } dir_e;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic fin;
    logic last_row;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic col_last;
    logic row_end;
  } status_t;

endpackage

FILE: design/lasm_if.sv
interface lasm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [lasm_pkg::SymbolW-1:0] symbol;
  logic                         last;

  modport source(output valid, action, symbol, last, input ready);
  modport sink(input valid, action, symbol, last, output ready);
endinterface

interface lasm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lasm_pkg::RowW-1:0]   row;
  logic [lasm_pkg::ColW-1:0]   column;
  logic [1:0]                  direction;
  logic [lasm_pkg::ScoreW-1:0] best_score;
  logic [lasm_pkg::IndexW-1:0] best_index;
  logic                        end_of_run;

  modport source(output valid, kind, row, column, direction, best_score, best_index,
                 end_of_run, input ready);
  modport sink(input valid, kind, row, column, direction, best_score, best_index,
               end_of_run, output ready);
endinterface

interface lasm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lasm_pkg::CfgIdxW-1:0]  index;
  logic [lasm_pkg::CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/lasm_ctrl.sv
module lasm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_action_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  lasm_pkg::status_t  status_i,
  output lasm_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRow,
    StFinal
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   accept;

  always_comb begin
    in_ready_o = (state_q == StIdle);
    accept     = in_valid_i && in_ready_o;

    cmd_o          = '0;
    cmd_o.load     = accept && (in_action_i == lasm_pkg::ActQuery);
    cmd_o.start    = accept && (in_action_i == lasm_pkg::ActDatabase);
    cmd_o.step     = (state_q == StRow) && status_i.out_free;
    cmd_o.fin      = (state_q == StFinal) && status_i.out_free;
    cmd_o.last_row = last_q;

    state_d = state_q;
    last_d  = last_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.start) begin
          state_d = StRow;
          last_d  = in_last_i || status_i.row_end;
        end
      end
      StRow: begin
        if (cmd_o.step && status_i.col_last) begin
          state_d = last_q ? StFinal : StIdle;
        end
      end
      StFinal: begin
        if (cmd_o.fin) begin
          state_d = StIdle;
          last_d  = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

FILE: design/lasm_dp.sv
module lasm_dp #(
  parameter int unsigned QUERY_LEN = lasm_pkg::QueryLenDefault,
  parameter int unsigned DB_LEN    = lasm_pkg::DbLenDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lasm_pkg::cmd_t               cmd_i,
  output lasm_pkg::status_t            status_o,
  input  logic [lasm_pkg::SymbolW-1:0] symbol_i,
  lasm_cfg_if.sink                     cfg_i,
  lasm_out_if.source                   out_o
);

  localparam int unsigned IdxW    = $clog2(QUERY_LEN);
  localparam int unsigned CntW    = $clog2(QUERY_LEN + 1);
  localparam int unsigned RowW    = lasm_pkg::RowW;
  localparam int unsigned ColW    = lasm_pkg::ColW;
  localparam int unsigned ScoreW  = lasm_pkg::ScoreW;
  localparam int unsigned IndexW  = lasm_pkg::IndexW;
  localparam int unsigned SymbolW = lasm_pkg::SymbolW;
  localparam int unsigned SW      = ScoreW + 2;

  localparam logic [RowW-1:0] LastRow = RowW'(DB_LEN - 1);
  localparam logic [IdxW-1:0] ColLast = IdxW'(QUERY_LEN - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUERY_LEN);

  logic        [3:0] match_q;
  logic signed [4:0] mismatch_q;
  logic signed [4:0] gap_n_q;
  logic signed [4:0] gap_w_q;

  logic [SymbolW-1:0] query_q [QUERY_LEN];
  logic [ScoreW-1:0]  prev_q  [QUERY_LEN];
  logic [ScoreW-1:0]  cbs_q   [QUERY_LEN];
  logic [RowW-1:0]    cbr_q   [QUERY_LEN];

  logic [SymbolW-1:0] symbol_q;
  logic [ScoreW-1:0]  nw_q;
  logic [ScoreW-1:0]  west_q;
  logic [RowW-1:0]    row_q;
  logic [CntW-1:0]    cnt_q;
  logic [IdxW-1:0]    col_q;
  logic [ScoreW-1:0]  best_q;
  logic [RowW-1:0]    brow_q;
  logic [IdxW-1:0]    bcol_q;

  logic                out_valid_q;
  logic                out_kind_q;
  logic [RowW-1:0]     out_row_q;
  logic [ColW-1:0]     out_col_q;
  logic [1:0]          out_dir_q;
  logic [ScoreW-1:0]   out_score_q;
  logic [IndexW-1:0]   out_index_q;
  logic                out_eor_q;

  logic signed [SW-1:0] diag;
  logic signed [SW-1:0] gn;
  logic signed [SW-1:0] gw;
  logic signed [SW-1:0] val;
  lasm_pkg::dir_e       dir;
  logic [ScoreW-1:0]    cell_score;
  logic                 take_cell;
  logic [ScoreW-1:0]    new_best;
  logic [RowW-1:0]      new_brow;
  logic                 run_take;
  logic [IndexW-1:0]    flat_index;

  always_comb begin
    diag = $signed({2'b00, nw_q}) + ((query_q[0] == symbol_q)
           ? $signed({{(SW - 4){1'b0}}, match_q}) : SW'(mismatch_q));
    gn   = $signed({2'b00, prev_q[0]}) + SW'(gap_n_q);
    gw   = $signed({2'b00, west_q}) + SW'(gap_w_q);

    if (gn >= gw) begin
      val = gn;
      dir = lasm_pkg::DirNorth;
    end else begin
      val = gw;
      dir = lasm_pkg::DirWest;
    end
    if (diag >= val) begin
      val = diag;
      dir = lasm_pkg::DirDiag;
    end
    if (val <= 0) begin
      val = '0;
      dir = lasm_pkg::DirRestart;
    end
    if (val > $signed({2'b00, lasm_pkg::ScoreMax})) begin
      cell_score = lasm_pkg::ScoreMax;
    end else begin
      cell_score = val[ScoreW-1:0];
    end

    take_cell = (cell_score >= cbs_q[0]);
    new_best  = take_cell ? cell_score : cbs_q[0];
    new_brow  = take_cell ? row_q : cbr_q[0];
    run_take  = (new_best >= best_q);

    flat_index = IndexW'(brow_q) * IndexW'(QUERY_LEN) + IndexW'(bcol_q);

    status_o.out_free = !out_valid_q || out_o.ready;
    status_o.col_last = (col_q == ColLast);
    status_o.row_end  = (row_q >= LastRow);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= 4'd2;
      mismatch_q <= -5'sd1;
      gap_n_q    <= -5'sd1;
      gap_w_q    <= -5'sd1;
    end else if (cfg_i.valid) begin
      case (lasm_pkg::cfg_reg_e'(cfg_i.index))
        lasm_pkg::RegMatch:    match_q    <= cfg_i.data[3:0];
        lasm_pkg::RegMismatch: mismatch_q <= $signed(cfg_i.data);
        lasm_pkg::RegGapNorth: gap_n_q    <= $signed(cfg_i.data);
        lasm_pkg::RegGapWest:  gap_w_q    <= $signed(cfg_i.data);
        default: begin
        end
      endcase
    end
  end

  // The query line rotates once per column, so a full row returns it to load order.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_q < CntFull)) begin
      query_q[cnt_q[IdxW-1:0]] <= symbol_i;
    end else if (cmd_i.step) begin
      for (int i = 0; i < QUERY_LEN - 1; i++) begin
        query_q[i] <= query_q[i+1];
      end
      query_q[QUERY_LEN-1] <= query_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUERY_LEN; i++) begin
        prev_q[i] <= '0;
        cbs_q[i]  <= '0;
        cbr_q[i]  <= '0;
      end
    end else if (cmd_i.fin) begin
      for (int i = 0; i < QUERY_LEN; i++) begin
        prev_q[i] <= '0;
        cbs_q[i]  <= '0;
        cbr_q[i]  <= '0;
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < QUERY_LEN - 1; i++) begin
        prev_q[i] <= prev_q[i+1];
        cbs_q[i]  <= cbs_q[i+1];
        cbr_q[i]  <= cbr_q[i+1];
      end
      prev_q[QUERY_LEN-1] <= cell_score;
      cbs_q[QUERY_LEN-1]  <= new_best;
      cbr_q[QUERY_LEN-1]  <= new_brow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      cnt_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fin) begin
        row_q <= '0;
        cnt_q <= '0;
      end else begin
        if (cmd_i.load && (cnt_q < CntFull)) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmd_i.step && status_o.col_last) begin
          row_q <= row_q + 1'b1;
        end
      end

      if (cmd_i.start) begin
        col_q <= '0;
      end else if (cmd_i.step) begin
        col_q <= status_o.col_last ? '0 : col_q + 1'b1;
      end

      if (cmd_i.step || cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      symbol_q <= symbol_i;
      nw_q     <= '0;
      west_q   <= '0;
      best_q   <= '0;
      brow_q   <= '0;
      bcol_q   <= '0;
    end else if (cmd_i.step) begin
      nw_q   <= prev_q[0];
      west_q <= cell_score;
      if (run_take) begin
        best_q <= new_best;
        brow_q <= new_brow;
        bcol_q <= col_q;
      end
    end

    if (cmd_i.step) begin
      out_kind_q  <= lasm_pkg::KindCell;
      out_row_q   <= row_q;
      out_col_q   <= ColW'(col_q);
      out_dir_q   <= dir;
      out_score_q <= '0;
      out_index_q <= '0;
      out_eor_q   <= status_o.col_last && !cmd_i.last_row;
    end else if (cmd_i.fin) begin
      out_kind_q  <= lasm_pkg::KindBest;
      out_row_q   <= brow_q;
      out_col_q   <= ColW'(bcol_q);
      out_dir_q   <= lasm_pkg::DirRestart;
      out_score_q <= best_q;
      out_index_q <= flat_index;
      out_eor_q   <= 1'b1;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.row        = out_row_q;
  assign out_o.column     = out_col_q;
  assign out_o.direction  = out_dir_q;
  assign out_o.best_score = out_score_q;
  assign out_o.best_index = out_index_q;
  assign out_o.end_of_run = out_eor_q;

`ifndef NO_ASSERTIONS
  a_step_needs_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step || cmd_i.fin) |-> status_o.out_free)
    else $error("A result was produced while the output register was still occupied.");

  a_fin_clears_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> (row_q == '0) && (cnt_q == '0))
    else $error("The run state was not cleared after the best-location result.");

  a_col_wraps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && status_o.col_last) |=> (col_q == '0))
    else $error("The column counter did not wrap after the last query column.");
`endif

endmodule

FILE: design/local_alignment_score_matrix_core.sv
// Smith-Waterman local alignment scorer with a linear gap score. Query characters are loaded
// first, one request each. Each database character then computes one row of
// the score matrix on a single shared cell unit, one query column per cycle while the output
// register is free, and delivers one direction result per column. On the final database
// character the block then delivers the best score and its location, and the run state is
// cleared as that result is registered. A new request is taken only when the current row is
// finished, and the configuration port is always ready.
module local_alignment_score_matrix_core #(
  parameter int unsigned QUERY_LEN = lasm_pkg::QueryLenDefault,
  parameter int unsigned DB_LEN    = lasm_pkg::DbLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lasm_in_if.sink    in_i,
  lasm_out_if.source out_o,
  lasm_cfg_if.sink   cfg_i
);

  lasm_pkg::cmd_t    cmd;
  lasm_pkg::status_t status;

  lasm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_action_i(in_i.action),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lasm_dp #(
    .QUERY_LEN(QUERY_LEN),
    .DB_LEN   (DB_LEN)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .status_o(status),
    .symbol_i(in_i.symbol),
    .cfg_i   (cfg_i),
    .out_o   (out_o)
  );

endmodule
